/* hw/rtl/iwdg_pkg.sv */
// Package: shared constants, request codes, result struct and divider helper for the watchdog.
`default_nettype none
package iwdg_pkg;

    localparam int RELOAD_BITS_DEF       = 12;
    localparam int MAX_PRESCALE_CODE_DEF = 6;
    localparam int SYNC_TICKS_DEF        = 5;

    localparam int REQ_W     = 3;
    localparam int DATA_W    = 16;
    localparam int CNT_OUT_W = 12;
    localparam int BUSY_W    = 6;
    localparam int CODE_W    = 3;
    localparam int DIV_W     = 8;

    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_KEY      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PRESCALE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RELOAD   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STATUS   = 3'd4;

    localparam logic [DATA_W-1:0] KEY_UNLOCK = 16'h5555;
    localparam logic [DATA_W-1:0] KEY_RELOAD = 16'hAAAA;
    localparam logic [DATA_W-1:0] KEY_START  = 16'hCCCC;

    localparam logic [DIV_W:0] DIV_BASE = 9'd4;
    localparam logic [DIV_W:0] DIV_CAP  = 9'd256;

    typedef struct packed {
        logic [1:0]           status_bits;
        logic [CNT_OUT_W-1:0] counter_value;
        logic                 is_running;
        logic                 is_unlocked;
        logic                 watchdog_reset;
    } iwdg_result_t;

    // Divide ratio: 4 << code, code saturated at max_code, ratio capped at 256
    function automatic logic [DIV_W:0] divide_ratio(input logic [CODE_W-1:0] code,
                                                    input logic [CODE_W-1:0] max_code);
        logic [CODE_W-1:0] sat;
        logic [DIV_W+7:0]  wide;
        logic [DIV_W:0]    ratio;
        sat   = (code > max_code) ? max_code : code;
        wide  = {{(DIV_W-1){1'b0}}, DIV_BASE} << sat;
        ratio = (wide > {{(DIV_W-1){1'b0}}, DIV_CAP}) ? DIV_CAP : wide[DIV_W:0];
        return ratio;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/iwdg_if.sv */
// Interfaces: request and result channels of the watchdog.
`default_nettype none
interface iwdg_req_if
    import iwdg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output req_type, output write_data, input ready);
    modport sink   (input valid, input req_type, input write_data, output ready);
endinterface

interface iwdg_res_if
    import iwdg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status_bits;
    logic [CNT_OUT_W-1:0] counter_value;
    logic                 is_running;
    logic                 is_unlocked;
    logic                 watchdog_reset;

    modport source (output valid, output status_bits, output counter_value,
                    output is_running, output is_unlocked, output watchdog_reset,
                    input ready);
    modport sink   (input valid, input status_bits, input counter_value,
                    input is_running, input is_unlocked, input watchdog_reset,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/iwdg_core.sv */
// Watchdog state registers and the single-pass update for one request beat.
`default_nettype none
module iwdg_core
    import iwdg_pkg::*;
#(
    parameter int RELOAD_BITS       = RELOAD_BITS_DEF,
    parameter int MAX_PRESCALE_CODE = MAX_PRESCALE_CODE_DEF,
    parameter int SYNC_TICKS        = SYNC_TICKS_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [DATA_W-1:0] write_data,
    output iwdg_result_t           result_next
);

    localparam logic [RELOAD_BITS-1:0] RELOAD_ONES = {RELOAD_BITS{1'b1}};
    localparam logic [BUSY_W-1:0]      BUSY_LOAD   = BUSY_W'(SYNC_TICKS);
    localparam logic [CODE_W-1:0]      MAX_CODE    = CODE_W'(MAX_PRESCALE_CODE);

    logic                   running_reg,  running_next;
    logic                   unlocked_reg, unlocked_next;
    logic [CODE_W-1:0]      code_reg,     code_next;
    logic [RELOAD_BITS-1:0] reload_reg,   reload_next;
    logic [RELOAD_BITS-1:0] count_reg,    count_next;
    logic [DIV_W-1:0]       div_reg,      div_next;
    logic [BUSY_W-1:0]      pbusy_reg,    pbusy_next;
    logic [BUSY_W-1:0]      rbusy_reg,    rbusy_next;
    logic                   expired;
    logic [DIV_W:0]         div_inc;

    assign div_inc = {1'b0, div_reg} + {{DIV_W{1'b0}}, 1'b1};

    always_comb
    begin
        running_next  = running_reg;
        unlocked_next = unlocked_reg;
        code_next     = code_reg;
        reload_next   = reload_reg;
        count_next    = count_reg;
        div_next      = div_reg;
        pbusy_next    = pbusy_reg;
        rbusy_next    = rbusy_reg;
        expired       = 1'b0;

        case (req_type)
            REQ_TICK:
            begin
                if (pbusy_reg != '0)
                begin
                    pbusy_next = pbusy_reg - 1'b1;
                end
                if (rbusy_reg != '0)
                begin
                    rbusy_next = rbusy_reg - 1'b1;
                end
                if (running_reg)
                begin
                    if (div_inc >= divide_ratio(code_reg, MAX_CODE))
                    begin
                        div_next = '0;
                        if (count_reg == '0)
                        begin
                            expired = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        div_next = div_inc[DIV_W-1:0];
                    end
                end
            end
            REQ_KEY:
            begin
                unlocked_next = (write_data == KEY_UNLOCK);
                if (write_data == KEY_RELOAD)
                begin
                    count_next = reload_reg;
                end
                if (write_data == KEY_START)
                begin
                    running_next = 1'b1;
                end
            end
            REQ_PRESCALE:
            begin
                if (unlocked_reg && pbusy_reg == '0)
                begin
                    code_next  = write_data[CODE_W-1:0];
                    pbusy_next = BUSY_LOAD;
                end
            end
            REQ_RELOAD:
            begin
                if (unlocked_reg && rbusy_reg == '0)
                begin
                    reload_next = write_data[RELOAD_BITS-1:0];
                    rbusy_next  = BUSY_LOAD;
                end
            end
            default:
            begin
                // status read and unused codes leave the state alone
            end
        endcase

        // expiry drops the whole block back to its reset values
        if (expired)
        begin
            running_next  = 1'b0;
            unlocked_next = 1'b0;
            code_next     = '0;
            reload_next   = RELOAD_ONES;
            count_next    = RELOAD_ONES;
            div_next      = '0;
            pbusy_next    = '0;
            rbusy_next    = '0;
        end

        result_next.status_bits    = {rbusy_next != '0, pbusy_next != '0};
        result_next.counter_value  = CNT_OUT_W'(count_next);
        result_next.is_running     = running_next;
        result_next.is_unlocked    = unlocked_next;
        result_next.watchdog_reset = expired;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            unlocked_reg <= 1'b0;
            code_reg     <= '0;
            reload_reg   <= RELOAD_ONES;
            count_reg    <= RELOAD_ONES;
            div_reg      <= '0;
            pbusy_reg    <= '0;
            rbusy_reg    <= '0;
        end
        else if (accept)
        begin
            running_reg  <= running_next;
            unlocked_reg <= unlocked_next;
            code_reg     <= code_next;
            reload_reg   <= reload_next;
            count_reg    <= count_next;
            div_reg      <= div_next;
            pbusy_reg    <= pbusy_next;
            rbusy_reg    <= rbusy_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/iwdg_out_reg.sv */
// Result register: holds one result beat and drives the result channel.
`default_nettype none
module iwdg_out_reg
    import iwdg_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire iwdg_result_t  result_next,
    output logic               can_load,
    iwdg_res_if.source         res
);

    logic         valid_reg;
    logic         valid_next;
    iwdg_result_t data_reg;

    // free when empty or when the held beat leaves this cycle
    assign can_load   = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_next;
        end
    end

    assign res.valid          = valid_reg;
    assign res.status_bits    = data_reg.status_bits;
    assign res.counter_value  = data_reg.counter_value;
    assign res.is_running     = data_reg.is_running;
    assign res.is_unlocked    = data_reg.is_unlocked;
    assign res.watchdog_reset = data_reg.watchdog_reset;

endmodule
`default_nettype wire

/* hw/rtl/independent_watchdog_device.sv */
// Top level: independent watchdog with request and result channels.
//
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+------------
//  req     | in  | req_type[2:0], write_data[15:0]                 | valid/ready
//  res     | out | status_bits, counter_value, is_running,         | valid/ready
//          |     | is_unlocked, watchdog_reset                     |
//
// One request beat per cycle while req.ready is high; its result appears in the result register the next cycle.
// The state update and result are one combinational pass from the state registers.
// req.ready is low only while a result beat is held and res.ready is low.
// rst_n clears the core state and result valid at once: counter and reload to all ones, flags and counts to 0.
`default_nettype none
module independent_watchdog_device
    import iwdg_pkg::*;
#(
    parameter int RELOAD_BITS       = RELOAD_BITS_DEF,
    parameter int MAX_PRESCALE_CODE = MAX_PRESCALE_CODE_DEF,
    parameter int SYNC_TICKS        = SYNC_TICKS_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    iwdg_req_if.sink   req,
    iwdg_res_if.source res
);

    logic         accept;
    logic         can_load;
    iwdg_result_t result_next;

    assign req.ready = can_load;
    assign accept    = req.valid && can_load;

    iwdg_core #(
        .RELOAD_BITS       (RELOAD_BITS),
        .MAX_PRESCALE_CODE (MAX_PRESCALE_CODE),
        .SYNC_TICKS        (SYNC_TICKS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req.req_type),
        .write_data  (req.write_data),
        .result_next (result_next)
    );

    iwdg_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .result_next (result_next),
        .can_load    (can_load),
        .res         (res)
    );

`ifndef SYNTH
    // an expiry beat carries the reset state
    a_expiry_state: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.watchdog_reset |->
            !res.is_running && !res.is_unlocked && res.status_bits == 2'b00)
        else $error("expiry beat does not show reset state");

    // a stalled result beat blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |-> !req.ready)
        else $error("request accepted over a stalled result");

    // an accepted request always yields a result beat next cycle
    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> res.valid)
        else $error("accepted request produced no result");
`endif

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench for the independent watchdog: directed and random request beats, checked against a local model.
module tb;
    import iwdg_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_GAP      = 11;
    localparam int TICK_BUDGET  = 600;
    localparam int RLD_W        = RELOAD_BITS_DEF;
    localparam int CODE_LIMIT   = MAX_PRESCALE_CODE_DEF;

    localparam logic [BUSY_W-1:0] SYNC_LOAD  = BUSY_W'(SYNC_TICKS_DEF);
    localparam logic [REQ_W-1:0]  REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_W-1:0]  REQ_SPARE_HI = 3'd7;

    typedef struct {
        logic              running;
        logic              unlocked;
        logic [CODE_W-1:0] code;
        logic [RLD_W-1:0]  reload;
        logic [RLD_W-1:0]  counter;
        logic [DIV_W-1:0]  divider;
        logic [BUSY_W-1:0] presc_busy;
        logic [BUSY_W-1:0] reload_busy;
    } wdg_state_t;

    logic clk = 1'b0;
    logic rst_n;

    iwdg_req_if req_ch();
    iwdg_res_if res_ch();

    independent_watchdog_device dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    wdg_state_t   wdg;
    iwdg_result_t pending_results[$];
    int           beats_sent;
    int           results_checked;
    int           mismatches;
    int           expiries;
    int           idle_cycles;
    int           sink_wait;
    int           sink_draw;
    bit           src_steady;
    bit           sink_steady;

    always #5 clk = ~clk;

    function automatic int divide_for(input logic [CODE_W-1:0] code);
        int c;
        int ratio;
        c     = (int'(code) > CODE_LIMIT) ? CODE_LIMIT : int'(code);
        ratio = int'(DIV_BASE) << c;
        return (ratio > int'(DIV_CAP)) ? int'(DIV_CAP) : ratio;
    endfunction

    function automatic void clear_watchdog();
        wdg.running     = 1'b0;
        wdg.unlocked    = 1'b0;
        wdg.code        = '0;
        wdg.reload      = '1;
        wdg.counter     = '1;
        wdg.divider     = '0;
        wdg.presc_busy  = '0;
        wdg.reload_busy = '0;
    endfunction

    function automatic iwdg_result_t step_watchdog(input logic [REQ_W-1:0] kind,
                                                   input logic [DATA_W-1:0] data);
        iwdg_result_t r;
        logic         fired;
        int           next_div;
        fired = 1'b0;
        case (kind)
            REQ_TICK:
            begin
                if (wdg.presc_busy != 0)
                    wdg.presc_busy--;
                if (wdg.reload_busy != 0)
                    wdg.reload_busy--;
                if (wdg.running)
                begin
                    next_div = int'(wdg.divider) + 1;
                    if (next_div >= divide_for(wdg.code))
                    begin
                        wdg.divider = '0;
                        if (wdg.counter == 0)
                            fired = 1'b1;
                        else
                            wdg.counter--;
                    end
                    else
                        wdg.divider = DIV_W'(next_div);
                end
                if (fired)
                begin
                    clear_watchdog();
                    expiries++;
                end
            end
            REQ_KEY:
            begin
                if (data == KEY_UNLOCK)
                    wdg.unlocked = 1'b1;
                else
                begin
                    wdg.unlocked = 1'b0;
                    if (data == KEY_RELOAD)
                        wdg.counter = wdg.reload;
                    else if (data == KEY_START)
                        wdg.running = 1'b1;
                end
            end
            REQ_PRESCALE:
            begin
                if (wdg.unlocked && wdg.presc_busy == 0)
                begin
                    wdg.code       = data[CODE_W-1:0];
                    wdg.presc_busy = SYNC_LOAD;
                end
            end
            REQ_RELOAD:
            begin
                if (wdg.unlocked && wdg.reload_busy == 0)
                begin
                    wdg.reload      = data[RLD_W-1:0];
                    wdg.reload_busy = SYNC_LOAD;
                end
            end
            default:
            begin
            end
        endcase
        r.status_bits    = {wdg.reload_busy != 0, wdg.presc_busy != 0};
        r.counter_value  = wdg.counter[CNT_OUT_W-1:0];
        r.is_running     = wdg.running;
        r.is_unlocked    = wdg.unlocked;
        r.watchdog_reset = fired;
        return r;
    endfunction

    function automatic void check_result();
        iwdg_result_t got;
        iwdg_result_t want;
        got.status_bits    = res_ch.status_bits;
        got.counter_value  = res_ch.counter_value;
        got.is_running     = res_ch.is_running;
        got.is_unlocked    = res_ch.is_unlocked;
        got.watchdog_reset = res_ch.watchdog_reset;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat with nothing outstanding: busy=%b count=%0d",
                         got.status_bits, got.counter_value);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got.status_bits !== want.status_bits || got.counter_value !== want.counter_value
            || got.is_running !== want.is_running || got.is_unlocked !== want.is_unlocked
            || got.watchdog_reset !== want.watchdog_reset)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: want busy=%b cnt=%0d run=%b unl=%b rst=%b, %s",
                         results_checked, want.status_bits, want.counter_value,
                         want.is_running, want.is_unlocked, want.watchdog_reset,
                         $sformatf("got busy=%b cnt=%0d run=%b unl=%b rst=%b",
                                   got.status_bits, got.counter_value, got.is_running,
                                   got.is_unlocked, got.watchdog_reset));
        end
    endfunction

    // result side: compare every accepted beat, track progress for the timeout
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res_ch.valid && res_ch.ready)
                check_result();
        end
    end

    // result sink: random stall after each accepted beat
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            sink_draw = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (sink_draw > 0)
            begin
                res_ch.ready <= 1'b0;
                sink_wait    <= sink_draw;
            end
        end
        else if (sink_wait > 0)
        begin
            if (sink_wait == 1)
                res_ch.ready <= 1'b1;
            sink_wait <= sink_wait - 1;
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("independent_watchdog_device verification failed");
        $finish;
    end

    // valid is left high after acceptance; the next call either reloads it or drops it
    task automatic send_beat(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] data);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.write_data <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(step_watchdog(kind, data));
        beats_sent++;
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic send_noise();
        logic [DATA_W-1:0] data;
        int                pick;
        pick = $urandom_range(0, 4);
        data = (pick == 0) ? KEY_UNLOCK : (pick == 1) ? KEY_RELOAD :
               (pick == 2) ? KEY_START : DATA_W'($urandom);
        send_beat(REQ_W'($urandom_range(0, 7)), data);
    endtask

    task automatic test_idle_requests();
        // reads and spare codes leave everything alone; ticks do nothing while stopped
        send_beat(REQ_STATUS, '0);
        for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
            send_beat(REQ_W'(k), (k % 2 != 0) ? 16'hFFFF : KEY_UNLOCK);
        send_beat(REQ_TICK, 16'hFFFF);
    endtask

    task automatic test_write_locking();
        send_beat(REQ_PRESCALE, 16'hFFFF);
        send_beat(REQ_RELOAD, 16'h0000);
        send_beat(REQ_KEY, KEY_UNLOCK);
        send_beat(REQ_PRESCALE, 16'hFFF8);
        send_beat(REQ_PRESCALE, 16'h0007);   // busy, dropped
        send_beat(REQ_RELOAD, 16'hF000);
        send_beat(REQ_RELOAD, 16'h0FFF);     // busy, dropped
        send_beat(REQ_KEY, 16'h1234);        // any other key locks
        repeat (SYNC_TICKS_DEF) send_beat(REQ_TICK, '0);
    endtask

    task automatic test_expiry();
        // reload is 0 and ratio 4: counter expires on the fourth tick
        send_beat(REQ_KEY, KEY_RELOAD);
        send_beat(REQ_KEY, KEY_START);
        repeat (int'(DIV_BASE)) send_beat(REQ_TICK, '0);
    endtask

    task automatic test_random_sessions();
        int                first;
        int                roll;
        int                budget;
        int                kicks;
        logic [DATA_W-1:0] data;
        logic [CODE_W-1:0] code;
        first = beats_sent;
        while (beats_sent - first < RANDOM_ITEMS)
        begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 3)) send_noise();
            send_beat(REQ_KEY, ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : KEY_UNLOCK);
            while (wdg.presc_busy != 0 || wdg.reload_busy != 0)
                send_beat(REQ_TICK, DATA_W'($urandom));

            roll = $urandom_range(0, 99);
            code = (roll < 55) ? 3'd0 : (roll < 80) ? CODE_W'($urandom_range(1, 2))
                                                    : CODE_W'($urandom_range(3, 7));
            data = DATA_W'($urandom);
            data[CODE_W-1:0] = code;
            send_beat(REQ_PRESCALE, data);

            // keep the expiry time short for the slow dividers
            data = DATA_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 5)
                data[RLD_W-1:0] = '1;
            else if (code > 2)
                data[RLD_W-1:0] = RLD_W'($urandom_range(0, 1));
            else if (code > 0)
                data[RLD_W-1:0] = RLD_W'($urandom_range(0, 3));
            else
                data[RLD_W-1:0] = RLD_W'($urandom_range(0, 15));
            send_beat(REQ_RELOAD, data);
            if ($urandom_range(0, 3) == 0)
                send_beat($urandom_range(0, 1) ? REQ_RELOAD : REQ_PRESCALE, DATA_W'($urandom));
            if ($urandom_range(0, 7) != 0)
                send_beat(REQ_KEY, KEY_RELOAD);
            send_beat(REQ_KEY, KEY_START);

            budget = TICK_BUDGET;
            kicks  = $urandom_range(0, 2);
            while (budget > 0 && wdg.running && beats_sent - first < RANDOM_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 88)
                    send_beat(REQ_TICK, DATA_W'($urandom));
                else if (roll < 91 && kicks > 0)
                begin
                    send_beat(REQ_KEY, KEY_RELOAD);
                    kicks--;
                end
                else if (roll < 96)
                    send_beat(REQ_STATUS, DATA_W'($urandom));
                else
                    send_noise();
                budget--;
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_results();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_TICK;
        req_ch.write_data = '0;
        res_ch.ready      = 1'b1;
        idle_cycles       = 0;
        sink_wait         = 0;
        src_steady        = 1'b0;
        sink_steady       = 1'b0;
        clear_watchdog();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_requests();
        test_write_locking();
        test_expiry();
        wait_for_results();
        test_random_sessions();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d request beats over lock, reload, start and expiry sequences.",
                 beats_sent);
        $display("Compared %0d result beats, saw %0d expiries, %0d mismatched.",
                 results_checked, expiries, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("independent_watchdog_device verification clean");
        else
            $display("independent_watchdog_device verification failed");
        $finish;
    end

endmodule
